// ===== src/aopb_pkg.sv =====
// ----------------------------------------------------------------------------
// aopb_pkg: shared types and constants for the alpha-over pixel blender
// Channel widths, the divider datapath word and the full-channel constant.
// ----------------------------------------------------------------------------
`default_nettype none

package aopb_pkg;

  localparam int unsigned PIX_W  = 32;  // packed pixel word
  localparam int unsigned CH_W   = 8;   // one colour or alpha byte
  localparam int unsigned CH_CNT = 3;   // red, green, blue
  localparam int unsigned DEN_W  = 16;  // sa*255 + da*(255-sa), at most 65025
  localparam int unsigned NUM_W  = 24;  // colour numerator, below 2^24

  localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [DEN_W-1:0] den_t;
  typedef logic [NUM_W-1:0] num_t;

  // Word carried down the divider pipeline: partial remainders and quotients
  // of the three colour channels, plus the shared denominator, out alpha and zero flag.
  typedef struct packed {
    num_t [CH_CNT-1:0]  rem;
    chan_t [CH_CNT-1:0] quo;
    den_t               den;
    chan_t              alpha;
    logic               zero;
  } div_word_t;

endpackage

`default_nettype wire

// ===== src/aopb_in_if.sv =====
// ----------------------------------------------------------------------------
// aopb_in_if: input channel of the alpha-over pixel blender
// Valid/ready channel carrying one destination and one source pixel per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface aopb_in_if;
  logic            valid;
  logic            ready;
  aopb_pkg::pixel_t destination_pixel;
  aopb_pkg::pixel_t source_pixel;

  modport source (output valid, output destination_pixel, output source_pixel,
                  input ready);
  modport sink   (input valid, input destination_pixel, input source_pixel,
                  output ready);
endinterface

`default_nettype wire

// ===== src/aopb_out_if.sv =====
// ----------------------------------------------------------------------------
// aopb_out_if: result channel of the alpha-over pixel blender
// Valid/ready channel carrying one blended pixel per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface aopb_out_if;
  logic             valid;
  logic             ready;
  aopb_pkg::pixel_t blended_pixel;

  modport source (output valid, output blended_pixel, input ready);
  modport sink   (input valid, input blended_pixel, output ready);
endinterface

`default_nettype wire

// ===== src/aopb_div_stage.sv =====
// ----------------------------------------------------------------------------
// aopb_div_stage: one registered step of the restoring colour divider
// Resolves quotient bit SHIFT of all three channels against the shared
// denominator and hands the word to the next stage.
// ----------------------------------------------------------------------------
`default_nettype none

module aopb_div_stage #(
  parameter int unsigned SHIFT = 0   // quotient bit resolved here, 0 .. CH_W-1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                valid_i,
  input  wire aopb_pkg::div_word_t word_i,
  output logic                     valid_o,
  output aopb_pkg::div_word_t      word_o
);

  aopb_pkg::num_t               dsh;
  logic [aopb_pkg::CH_CNT-1:0]  take;
  aopb_pkg::div_word_t          word_nxt;
  logic                         valid_r;
  aopb_pkg::div_word_t          word_r;

  assign dsh = aopb_pkg::num_t'(word_i.den) << SHIFT;

  always_comb begin
    word_nxt = word_i;
    for (int c = 0; c < aopb_pkg::CH_CNT; c++) begin
      take[c] = (word_i.rem[c] >= dsh);
      // subtract the shifted divisor when it fits
      word_nxt.rem[c]        = take[c] ? (word_i.rem[c] - dsh) : word_i.rem[c];
      word_nxt.quo[c][SHIFT] = take[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;

endmodule

`default_nettype wire

// ===== src/alpha_over_pixel_blend_top.sv =====
// ----------------------------------------------------------------------------
// alpha_over_pixel_blend_top: straight-alpha source-over pixel compositor
// Lays a source pixel over a destination pixel in exact integer arithmetic.
// ----------------------------------------------------------------------------
// Takes one destination/source pixel pair per clock and returns one blended
// pixel per clock, in order, while the output is not stalled. An accepted word
// passes through ten register stages before it is a valid output word: one
// forms the alpha weights and denominator, one forms the colour numerators
// and output alpha, and eight run a restoring divider that settles one
// quotient bit of each colour channel per stage. Each stage holds its word
// only while the stage after it is full and stalled, so bubbles close up and
// ready stays high until all ten stages hold data. Bytes are red, green, blue,
// alpha from the least significant; when both alphas are zero the result is
// all zero.
`default_nettype none

module alpha_over_pixel_blend_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  aopb_in_if.sink    in_ch,
  aopb_out_if.source out_ch
);

  localparam int unsigned DIV_STAGES = aopb_pkg::CH_W;
  localparam int unsigned PIPE_DEPTH = DIV_STAGES + 2;
  localparam int unsigned LAST       = PIPE_DEPTH - 1;

  logic [PIPE_DEPTH-1:0] v;
  logic [PIPE_DEPTH-1:0] en;

  // ---- stage 0: alpha weights and denominator ----
  aopb_pkg::chan_t  sa;
  aopb_pkg::chan_t  da;
  aopb_pkg::den_t   sw_nxt;
  aopb_pkg::den_t   dw_nxt;
  aopb_pkg::den_t   den_nxt;

  logic             s0_v_r;
  aopb_pkg::pixel_t s0_dst_r;
  aopb_pkg::pixel_t s0_src_r;
  aopb_pkg::den_t   s0_sw_r;
  aopb_pkg::den_t   s0_dw_r;
  aopb_pkg::den_t   s0_den_r;

  assign sa      = in_ch.source_pixel[aopb_pkg::PIX_W-1 -: aopb_pkg::CH_W];
  assign da      = in_ch.destination_pixel[aopb_pkg::PIX_W-1 -: aopb_pkg::CH_W];
  assign sw_nxt  = {sa, aopb_pkg::CH_W'(0)} - aopb_pkg::den_t'(sa);
  assign dw_nxt  = aopb_pkg::den_t'(da) * aopb_pkg::den_t'(aopb_pkg::CH_MAX - sa);
  assign den_nxt = sw_nxt + dw_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en[0]) begin
      s0_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_dst_r <= in_ch.destination_pixel;
      s0_src_r <= in_ch.source_pixel;
      s0_sw_r  <= sw_nxt;
      s0_dw_r  <= dw_nxt;
      s0_den_r <= den_nxt;
    end
  end

  // ---- stage 1: colour numerators, out alpha = den / 255 ----
  logic [aopb_pkg::DEN_W:0] a_sum;
  aopb_pkg::div_word_t      d0_nxt;
  logic                     d0_v_r;
  aopb_pkg::div_word_t      d0_word_r;

  // exact floor(x/255) for x below 65535: (x + 1 + (x >> 8)) >> 8
  assign a_sum = {1'b0, s0_den_r} + (aopb_pkg::DEN_W+1)'(1)
               + (aopb_pkg::DEN_W+1)'(s0_den_r[aopb_pkg::DEN_W-1:aopb_pkg::CH_W]);

  always_comb begin
    d0_nxt       = '0;
    d0_nxt.den   = s0_den_r;
    d0_nxt.alpha = a_sum[2*aopb_pkg::CH_W-1:aopb_pkg::CH_W];
    d0_nxt.zero  = (s0_den_r == '0);
    for (int c = 0; c < aopb_pkg::CH_CNT; c++) begin
      d0_nxt.rem[c] =
          aopb_pkg::num_t'(s0_src_r[c*aopb_pkg::CH_W +: aopb_pkg::CH_W])
            * aopb_pkg::num_t'(s0_sw_r)
        + aopb_pkg::num_t'(s0_dst_r[c*aopb_pkg::CH_W +: aopb_pkg::CH_W])
            * aopb_pkg::num_t'(s0_dw_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0_v_r <= 1'b0;
    end else if (en[1]) begin
      d0_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d0_word_r <= d0_nxt;
    end
  end

  // ---- stages 2 .. 9: restoring divider, quotient MSB first ----
  aopb_pkg::div_word_t dword [0:DIV_STAGES];

  assign dword[0] = d0_word_r;
  assign v[0]     = s0_v_r;
  assign v[1]     = d0_v_r;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    aopb_div_stage #(
      .SHIFT (DIV_STAGES - 1 - k)
    ) u_div_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en[k+2]),
      .valid_i (v[k+1]),
      .word_i  (dword[k]),
      .valid_o (v[k+2]),
      .word_o  (dword[k+1])
    );
  end

  // ---- flow control: a stage advances when empty or when its successor does ----
  assign en[LAST] = !v[LAST] || out_ch.ready;
  for (genvar k = 0; k < LAST; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end

  assign in_ch.ready = en[0];

  // ---- output word ----
  assign out_ch.valid         = v[LAST];
  assign out_ch.blended_pixel = dword[DIV_STAGES].zero ? '0 :
                                {dword[DIV_STAGES].alpha, dword[DIV_STAGES].quo};

`ifndef NO_ASSERTIONS
  // every colour division must finish with a remainder below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (v[LAST] && !dword[DIV_STAGES].zero) |->
      (dword[DIV_STAGES].rem[0] < aopb_pkg::num_t'(dword[DIV_STAGES].den)) &&
      (dword[DIV_STAGES].rem[1] < aopb_pkg::num_t'(dword[DIV_STAGES].den)) &&
      (dword[DIV_STAGES].rem[2] < aopb_pkg::num_t'(dword[DIV_STAGES].den)))
    else $error("divider remainder not below denominator");

  // out alpha is floor(den / 255)
  a_alpha_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    v[LAST] |->
      (aopb_pkg::den_t'(dword[DIV_STAGES].alpha) * aopb_pkg::den_t'(aopb_pkg::CH_MAX)
         <= dword[DIV_STAGES].den) &&
      ((dword[DIV_STAGES].den - aopb_pkg::den_t'(dword[DIV_STAGES].alpha)
         * aopb_pkg::den_t'(aopb_pkg::CH_MAX)) < aopb_pkg::den_t'(aopb_pkg::CH_MAX)))
    else $error("output alpha is not den / 255");

  // input backpressure only when every stage holds a word
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v))
    else $error("input stalled while the pipeline has a bubble");

  // a freshly reset pipeline shows no output word
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire
